/* src/assert_macros.svh */
// Assertion macros for the RTL files, included by led_command_frame_parser.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_CLK_NORST(lbl, clk, prop, msg)
`endif
`endif

/* src/lcfp_pkg.sv */
// Constants and types for the LED command frame parser.
// No dependencies; imported by led_command_frame_parser.
package lcfp_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'hAA;
  localparam logic [7:0] LED_ID_RED   = 8'h01;
  localparam logic [7:0] LED_ID_GREEN = 8'h02;
  localparam logic [7:0] LED_ID_BLUE  = 8'h03;
  localparam logic [7:0] STATE_OFF    = 8'h00;

  localparam int POS_W   = 9;
  localparam int OUT_W   = 16;

  // Result word as it leaves on the master side, lowest bit last in the list.
  typedef struct packed {
    logic [3:0] pad;
    logic       frame_valid;
    logic       blue_on;
    logic       green_on;
    logic       red_on;
    logic [7:0] echo_byte;
  } result_t;

endpackage

/* src/led_command_frame_parser.sv */
// LED command frame parser: checks header, length and checksum of byte frames
// and applies LED on/off pairs at the end of a valid frame. Uses lcfp_pkg.
//
// Usage:
//   The slave side takes one received byte per word in s_axis_tdata[7:0];
//   s_axis_tlast marks the last byte of a frame. Every accepted word gives
//   exactly one result word on the master side: the echoed byte, the LED
//   drive after that byte and, on the closing byte, the frame verdict.
//   m_axis_tlast is high on the result of a frame's closing byte.
// Timing and throughput:
//   A result is registered on the edge that accepts its byte. One byte is taken
//   every cycle while the receiver takes results; the frame state and the single
//   output register are updated in the same edge, so the rate is set only by the output register.
// Stall behavior:
//   When the receiver holds m_axis_tready low with a result waiting, the
//   output register holds and s_axis_tready drops until the result is taken.
// Reset:
//   rst clears the frame state, turns all LEDs off and empties the output.
//   The block is ready for a byte once reset is released.
`include "assert_macros.svh"

module led_command_frame_parser
  import lcfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] rx_byte
  input  logic             s_axis_tlast,  // end_of_frame
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // [7:0] echo_byte, [8] red_on, [9] green_on,
                                          // [10] blue_on, [11] frame_valid, [15:12] zero
  output logic             m_axis_tlast   // frame_done
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_sum, running_sum_next;
  logic             header_seen, header_seen_next;
  logic [7:0]       length_byte, length_byte_next;
  logic [7:0]       pair_id, pair_id_next;
  logic [2:0]       pending_written, pending_written_next;
  logic [2:0]       pending_value, pending_value_next;
  logic [2:0]       led_state, led_state_next;

  logic             s_fire;
  logic [7:0]       rx_byte;
  logic             pos_sat;
  logic [2:0]       id_bit;
  logic [POS_W-1:0] frame_len;
  logic             valid_c;
  result_t          result;
  result_t          out_word;
  logic             out_last;
  logic             out_valid;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;
  assign pos_sat       = byte_position[POS_W-1];
  assign frame_len     = byte_position + POS_W'(1);

  always_comb begin
    case (pair_id)
      LED_ID_RED:   id_bit = 3'b001;
      LED_ID_GREEN: id_bit = 3'b010;
      LED_ID_BLUE:  id_bit = 3'b100;
      default:      id_bit = 3'b000;
    endcase
  end

  always_comb begin
    byte_position_next   = byte_position;
    running_sum_next     = running_sum;
    header_seen_next     = header_seen;
    length_byte_next     = length_byte;
    pair_id_next         = pair_id;
    pending_written_next = pending_written;
    pending_value_next   = pending_value;
    led_state_next       = led_state;
    valid_c              = 1'b0;

    if (byte_position == '0) begin
      header_seen_next = (rx_byte == FRAME_HEADER);
    end else if (byte_position == POS_W'(1)) begin
      length_byte_next = rx_byte;
    end else if (!pos_sat) begin
      if (!byte_position[0]) begin
        pair_id_next = rx_byte;
      end else begin
        // Odd positions carry the state byte; the checksum byte may be one too.
        pending_written_next = pending_written | id_bit;
        if (rx_byte != STATE_OFF) begin
          pending_value_next = pending_value | id_bit;
        end else begin
          pending_value_next = pending_value & ~id_bit;
        end
      end
    end

    if (s_axis_tlast) begin
      valid_c = header_seen && !pos_sat && (byte_position >= POS_W'(2)) &&
                ({1'b0, length_byte} == frame_len) && (running_sum == rx_byte);
      if (valid_c) begin
        led_state_next = (led_state & ~pending_written_next) |
                         (pending_value_next & pending_written_next);
      end
      byte_position_next   = '0;
      running_sum_next     = '0;
      header_seen_next     = 1'b0;
      length_byte_next     = '0;
      pair_id_next         = '0;
      pending_written_next = '0;
      pending_value_next   = '0;
    end else begin
      running_sum_next = running_sum + rx_byte;
      if (!pos_sat) begin
        byte_position_next = frame_len;
      end
    end
  end

  always_comb begin
    result             = '0;
    result.echo_byte   = rx_byte;
    result.red_on      = led_state_next[0];
    result.green_on    = led_state_next[1];
    result.blue_on     = led_state_next[2];
    result.frame_valid = valid_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      running_sum     <= '0;
      header_seen     <= 1'b0;
      length_byte     <= '0;
      pair_id         <= '0;
      pending_written <= '0;
      pending_value   <= '0;
      led_state       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s_fire) begin
        byte_position   <= byte_position_next;
        running_sum     <= running_sum_next;
        header_seen     <= header_seen_next;
        length_byte     <= length_byte_next;
        pair_id         <= pair_id_next;
        pending_written <= pending_written_next;
        pending_value   <= pending_value_next;
        led_state       <= led_state_next;
        out_valid       <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_word <= result;
      out_last <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;
  assign m_axis_tlast  = out_last;

  `ASSERT_CLK(a_pos_cleared_after_last, clk, rst,
    (s_fire && s_axis_tlast) |=> (byte_position == '0),
    "frame state not cleared after closing byte")
  `ASSERT_CLK(a_pos_saturates, clk, rst,
    byte_position <= POS_W'(256),
    "byte position passed its saturation value")
  `ASSERT_CLK_NORST(a_led_only_on_valid_close, clk,
    (led_state != $past(led_state)) |->
      ($past(rst) || $past(s_fire && s_axis_tlast && valid_c)),
    "LED state changed outside a valid frame close")

endmodule
